@@ sv/spq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: sizes, command
// and status codes, transaction payloads and the per-cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 5;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               command;
        logic [DATA_W-1:0]        element_handle;
        logic signed [DATA_W-1:0] priority_value;
    } req_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_handle;
        logic [1:0]        status;
        logic              is_empty;
        logic              is_full;
    } rsp_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]        handle;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic load_left;
        logic load_new;
        logic load_right;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/spq_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming priority, and loads from its left neighbor, the new entry or its
// right neighbor as told.
// ----------------------------------------------------------------------------
module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire spq_pkg::entry_t    new_entry,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire spq_pkg::entry_t    right_entry,
    input  wire logic               occupied,
    output spq_pkg::entry_t         entry,
    output logic                    greater
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Signed compare: held priority strictly above the incoming one.
    assign greater = occupied && (entry_reg.prio > new_entry.prio);
    assign entry   = entry_reg;

    always_comb
    begin
        priority case (1'b1)
            ctrl.load_left:  entry_next = left_entry;
            ctrl.load_new:   entry_next = new_entry;
            ctrl.load_right: entry_next = right_entry;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

@@ sv/sorted_priority_queue_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted priority queue built as a chain of entry cells with a registered
// response stage.
// ----------------------------------------------------------------------------
// Each request transaction carries a command (enqueue, dequeue, peek), a
// handle and a signed priority, and yields exactly one response transaction
// with the front handle (zero unless a dequeue or peek finds an entry), a
// status code and the empty/full flags after the step. Entries sit in a row
// of DEPTH cells kept sorted ascending; every cell compares its priority
// with the incoming one in parallel, so an enqueue shifts the larger entries
// one cell right and a dequeue shifts the whole row one cell left. A new
// request is taken every cycle while the response register is free or being
// drained. Equal priorities leave in arrival order. The capacity value (cfg
// port, always ready) is saturated to DEPTH when used; write it only while
// the queue is idle.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire spq_pkg::req_item_t              req_data,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output spq_pkg::rsp_item_t                   rsp_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [spq_pkg::CAP_W-1:0]       cfg_data
);

    localparam int N = spq_pkg::DEPTH;

    logic [spq_pkg::CAP_W-1:0] cap_reg;
    logic [spq_pkg::CNT_W-1:0] count_reg;
    logic [spq_pkg::CNT_W-1:0] count_next;
    logic [spq_pkg::CNT_W-1:0] eff_cap;
    logic                      rsp_valid_reg;
    spq_pkg::rsp_item_t        rsp_data_reg;
    spq_pkg::rsp_item_t        rsp_data_next;

    spq_pkg::entry_t           new_entry;
    spq_pkg::entry_t           cell_entry [N];
    spq_pkg::cell_ctrl_t       cell_ctrl  [N];
    logic [N-1:0]              gt_vec;
    logic [N-1:0]              occ_vec;
    logic [N-1:0]              load_new_vec;

    logic accept;
    logic full;
    logic enq_go;
    logic deq_go;
    logic front_read;

    // The response register frees up when it is empty or being taken.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Saturate the capacity to the number of cells.
    assign eff_cap = (int'(cap_reg) > N) ? spq_pkg::CNT_W'(N)
                                         : spq_pkg::CNT_W'(cap_reg);
    assign full    = count_reg >= eff_cap;

    assign enq_go     = accept && (req_data.command == spq_pkg::CMD_ENQUEUE) && !full;
    assign deq_go     = accept && (req_data.command == spq_pkg::CMD_DEQUEUE)
                        && (count_reg != '0);
    assign front_read = ((req_data.command == spq_pkg::CMD_DEQUEUE)
                        || (req_data.command == spq_pkg::CMD_PEEK)) && (count_reg != '0);

    assign new_entry.handle = req_data.element_handle;
    assign new_entry.prio   = req_data.priority_value;

    // Cells below the count hold live entries.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            occ_vec[i] = spq_pkg::CNT_W'(i) < count_reg;
        end
    end

    // Per-cell steering. The greater-than mask is a run of ones at the tail of
    // the occupied cells, so the new entry lands where the run starts, or at
    // the first free cell when no held entry is larger.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            logic gt_prev;
            gt_prev = (i == 0) ? 1'b0 : gt_vec[(i == 0) ? 0 : i - 1];
            cell_ctrl[i].load_left   = enq_go && gt_prev;
            cell_ctrl[i].load_new    = enq_go && !gt_prev
                                       && (gt_vec[i] || (count_reg == spq_pkg::CNT_W'(i)));
            cell_ctrl[i].load_right  = deq_go && (i < N - 1);
            load_new_vec[i]          = cell_ctrl[i].load_new;
        end
    end

    generate
        for (genvar g = 0; g < N; g++)
        begin : g_cell
            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl[g]),
                .new_entry   (new_entry),
                .left_entry  (cell_entry[(g == 0) ? 0 : g - 1]),
                .right_entry (cell_entry[(g == N - 1) ? g : g + 1]),
                .occupied    (occ_vec[g]),
                .entry       (cell_entry[g]),
                .greater     (gt_vec[g])
            );
        end
    endgenerate

    // Advance the count and build the response for this transaction.
    always_comb
    begin
        count_next = count_reg;
        if (enq_go)
        begin
            count_next = count_reg + spq_pkg::CNT_W'(1);
        end
        else if (deq_go)
        begin
            count_next = count_reg - spq_pkg::CNT_W'(1);
        end

        rsp_data_next.out_handle = front_read ? cell_entry[0].handle : '0;
        unique case (req_data.command)
            spq_pkg::CMD_ENQUEUE:
                rsp_data_next.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
            spq_pkg::CMD_DEQUEUE,
            spq_pkg::CMD_PEEK:
                rsp_data_next.status = (count_reg == '0) ? spq_pkg::ST_EMPTY
                                                         : spq_pkg::ST_OK;
            default:
                rsp_data_next.status = spq_pkg::ST_OK;
        endcase
        rsp_data_next.is_empty = (count_next == '0);
        rsp_data_next.is_full  = (count_next >= eff_cap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= spq_pkg::CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the payload until the response transaction completes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= N)
        else $error("entry count above depth");

    a_single_insert: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load_new_vec))
        else $error("new entry loaded into more than one cell");

    a_enq_lands: assert property (@(posedge clk) disable iff (!rst_n)
        enq_go |-> $onehot(load_new_vec))
        else $error("enqueue must land in exactly one cell");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        enq_go |=> (count_reg == $past(count_reg) + spq_pkg::CNT_W'(1)))
        else $error("count did not advance on enqueue");

    a_empty_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status == spq_pkg::ST_EMPTY)) |-> (rsp_data.out_handle == '0))
        else $error("empty response carries a handle");

endmodule
`default_nettype wire
